// ===== rtl/stable_sorted_priority_queue_unit_macros.svh =====
// Assertion macros for the stable sorted priority queue unit.
// Used by stable_sorted_priority_queue_unit.sv; no other dependencies.
`ifndef STABLE_SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SSPQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sspq assertion failed");
`define SSPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sspq assertion failed");
`else
`define SSPQ_ASSERT_NOW(label, ante, cons)
`define SSPQ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/sspq_pkg.sv =====
// Package for the stable sorted priority queue unit.
// Holds transaction structs, the entry type and operation codes; no dependencies.
package sspq_pkg;

    localparam logic [1:0] KIND_JOIN  = 2'd0;
    localparam logic [1:0] KIND_LEAVE = 2'd1;
    localparam logic [1:0] KIND_PEEK  = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] join_priority;
        logic [15:0] join_payload;
    } t_in;

    typedef struct packed {
        logic [15:0] head_payload;
        logic        head_valid;
        logic        now_empty;
        logic        join_dropped;
    } t_out;

    typedef struct packed {
        logic        valid;
        logic [15:0] prio;
        logic [15:0] payload;
    } t_entry;

    typedef struct packed {
        logic        do_join;
        logic        do_leave;
        logic [15:0] prio;
        logic [15:0] payload;
    } t_cell_cmd;

endpackage

// ===== rtl/stable_sorted_priority_queue_unit.sv =====
// Stable sorted priority queue: top level with the cell chain and result register.
// Depends on sspq_pkg, sspq_cell and stable_sorted_priority_queue_unit_macros.svh.
//
// Usage:
//   Input channel i_valid/o_ready carries i_data (kind, join_priority, join_payload).
//   Output channel o_valid/i_ready carries o_data, one result per input transaction.
//   Join inserts behind all entries of equal or lower priority value; leave pops
//   the head; peek reads the head. Entries live in a chain of CAPACITY cells,
//   cell 0 the head; every cell compares against the joining priority at once.
//   The result is registered and valid in the cycle after acceptance.
//   One transaction is accepted per cycle unless the receiver stalls the result.
//   A join into a full queue is dropped and flagged in join_dropped.
//   Reset clears all cell valid bits and the result valid flag; the queue is empty.
//   When the receiver stalls, the result holds and o_ready drops until it is
//   taken; o_ready is high whenever the result register is empty or being read.
`include "stable_sorted_priority_queue_unit_macros.svh"
module stable_sorted_priority_queue_unit
    import sspq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    t_entry    w_entry [CAPACITY];
    logic      w_keep  [CAPACITY];
    t_cell_cmd w_cmd;
    logic      w_fire;
    logic      w_full;
    logic      w_empty;
    logic      w_drop;
    logic      w_sorted;
    logic [CAPACITY-1:0] w_valid_vec;

    logic r_out_valid;
    t_out r_out_data, n_out_data;

    assign o_ready = !r_out_valid || i_ready;
    assign w_fire  = i_valid && o_ready;
    assign w_full  = w_entry[CAPACITY-1].valid;
    assign w_empty = !w_entry[0].valid;
    assign w_drop  = w_fire && (i_data.kind == KIND_JOIN) && w_full;

    assign w_cmd.do_join  = w_fire && (i_data.kind == KIND_JOIN) && !w_full;
    assign w_cmd.do_leave = w_fire && (i_data.kind == KIND_LEAVE) && !w_empty;
    assign w_cmd.prio     = i_data.join_priority;
    assign w_cmd.payload  = i_data.join_payload;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry w_left;
        logic   w_left_keep;
        t_entry w_right;
        if (g == 0) begin : g_head
            assign w_left      = '0;
            assign w_left_keep = 1'b1;
        end else begin : g_mid
            assign w_left      = w_entry[g-1];
            assign w_left_keep = w_keep[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_body
            assign w_right = w_entry[g+1];
        end
        sspq_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_left      (w_left),
            .i_left_keep (w_left_keep),
            .i_right     (w_right),
            .o_entry     (w_entry[g]),
            .o_keep      (w_keep[g])
        );
        assign w_valid_vec[g] = w_entry[g].valid;
    end

    always_comb begin
        n_out_data = '0;
        case (i_data.kind)
            KIND_JOIN: begin
                n_out_data.join_dropped = w_full;
                n_out_data.now_empty    = 1'b0;
            end
            KIND_LEAVE: begin
                n_out_data.head_valid   = !w_empty;
                n_out_data.head_payload = w_empty ? 16'd0 : w_entry[0].payload;
                n_out_data.now_empty    = w_empty || !w_entry[1].valid;
            end
            KIND_PEEK: begin
                n_out_data.head_valid   = !w_empty;
                n_out_data.head_payload = w_empty ? 16'd0 : w_entry[0].payload;
                n_out_data.now_empty    = w_empty;
            end
            default: begin
                n_out_data.now_empty = w_empty;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ready) begin
            r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    // adjacent valid entries must stay in nondecreasing priority order
    always_comb begin
        w_sorted = 1'b1;
        for (int k = 1; k < CAPACITY; k++) begin
            if (w_entry[k].valid && (w_entry[k-1].prio > w_entry[k].prio)) begin
                w_sorted = 1'b0;
            end
        end
    end

    `SSPQ_ASSERT_NOW(a_valid_prefix, 1'b1, ((w_valid_vec + CAPACITY'(1)) & w_valid_vec) == '0)
    `SSPQ_ASSERT_NOW(a_sorted, 1'b1, w_sorted)
    `SSPQ_ASSERT_NEXT(a_drop_full, w_drop, o_valid && o_data.join_dropped && w_full)
    `SSPQ_ASSERT_NEXT(a_leave_head, w_cmd.do_leave, o_valid && o_data.head_valid)

endmodule

// ===== rtl/sspq_cell.sv =====
// One slot of the sorted chain: holds an entry and shifts toward either neighbor.
// Depends on sspq_pkg.
module sspq_cell
    import sspq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    input  t_entry    i_left,
    input  logic      i_left_keep,
    input  t_entry    i_right,
    output t_entry    o_entry,
    output logic      o_keep
);

    logic        r_valid, n_valid;
    logic [15:0] r_prio, n_prio;
    logic [15:0] r_payload, n_payload;

    // a valid entry stays put on a join: not greater than the joining priority
    assign o_keep  = r_valid && (r_prio <= i_cmd.prio);
    assign o_entry = '{valid: r_valid, prio: r_prio, payload: r_payload};

    always_comb begin
        n_valid   = r_valid;
        n_prio    = r_prio;
        n_payload = r_payload;
        if (i_cmd.do_join && !o_keep) begin
            if (i_left_keep) begin
                n_valid   = 1'b1;
                n_prio    = i_cmd.prio;
                n_payload = i_cmd.payload;
            end else begin
                n_valid   = i_left.valid;
                n_prio    = i_left.prio;
                n_payload = i_left.payload;
            end
        end else if (i_cmd.do_leave) begin
            n_valid   = i_right.valid;
            n_prio    = i_right.prio;
            n_payload = i_right.payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prio    <= n_prio;
        r_payload <= n_payload;
    end

endmodule
